// ===== hdl/signed_word_alu_with_overflow_assert.svh =====
// assertion macros for the signed word alu
`ifndef SIGNED_WORD_ALU_WITH_OVERFLOW_ASSERT_SVH
`define SIGNED_WORD_ALU_WITH_OVERFLOW_ASSERT_SVH
// checks that an implication holds on every edge outside reset
`define SWA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// checks an implication regardless of reset
`define SWA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// ===== hdl/swalu_pkg.sv =====
`timescale 1ns / 1ps
package swalu_pkg;
  localparam int unsigned DataW = 32;
  localparam int unsigned CmdW = 5;
  localparam int unsigned ErrW = 2;
  localparam int unsigned StageCnt = DataW + 2;
  localparam logic [5:0] CountMask = 6'h3f;

  typedef enum logic [CmdW-1:0] {
    CMD_ADD = 5'd0, CMD_SUB = 5'd1, CMD_MUL = 5'd2, CMD_DIV = 5'd3,
    CMD_AND = 5'd4, CMD_OR = 5'd5, CMD_XOR = 5'd6, CMD_SLA = 5'd7,
    CMD_SLL = 5'd8, CMD_SRA = 5'd9, CMD_SRL = 5'd10, CMD_EQ = 5'd11,
    CMD_NE = 5'd12, CMD_LE = 5'd13, CMD_LT = 5'd14, CMD_GE = 5'd15,
    CMD_GT = 5'd16
  } cmd_t;

  typedef enum logic [ErrW-1:0] {
    ERR_NONE = 2'd0, ERR_HIGH = 2'd1, ERR_LOW = 2'd2
  } err_t;

  // work travelling down the divider pipe alongside each word
  typedef struct packed {
    logic [CmdW-1:0]  cmd;
    logic [DataW-1:0] simple;   // result of logic, shift and compare commands
    logic [ErrW-1:0]  simple_err;
    logic [63:0]      exact;    // sign-extended add/sub/mul result
    logic             quot_neg;
    logic             div_zero;
  } side_t;
endpackage

// ===== hdl/signed_word_alu_with_overflow.sv =====
`timescale 1ns / 1ps
// signed 32-bit alu with overflow flags. one word is accepted per cycle and
// its result passes through the front stage, 32 divider stages and the back
// stage; every command walks the full pipe so results stay in order. the
// divider resolves one quotient bit per stage.
// the whole pipe advances when the output register is empty or being taken,
// so s_tready follows m_tready and a stall holds every stage in place.
// add/sub/mul/div saturate to 0 with error 1 (above range) or 2 (below);
// divide by zero gives 0 with no error.
module signed_word_alu_with_overflow (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // command [4:0], operand_a [36:5], operand_b [68:37], zero fill to 72
  input  logic [71:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // value [31:0], error_code [33:32], zero fill to 40
  output logic [39:0] m_tdata
);
  import swalu_pkg::*;
  `include "signed_word_alu_with_overflow_assert.svh"

  logic en;
  logic [CmdW-1:0] cmd;
  logic signed [DataW-1:0] opa, opb;
  logic vld [DataW+1];
  side_t sd [DataW+1];
  logic [DataW-1:0] rem [DataW+1];
  logic [DataW-1:0] quo [DataW+1];
  logic [DataW-1:0] dvs [DataW+1];
  logic [DataW-1:0] value;
  logic [ErrW-1:0] error_code;

  // pipe moves whenever the final register can be refilled
  assign en = !m_tvalid || m_tready;
  assign s_tready = en;
  assign cmd = s_tdata[4:0];
  assign opa = s_tdata[36:5];
  assign opb = s_tdata[68:37];

  swalu_front u_front (
    .clk, .rst, .en, .in_valid(s_tvalid), .cmd, .a(opa), .b(opb),
    .out_valid(vld[0]), .side(sd[0]), .mag_a(quo[0]), .mag_b(dvs[0])
  );
  assign rem[0] = '0;

  for (genvar i = 0; i < DataW; i++) begin : g_div
    swalu_div_stage u_stage (
      .clk, .rst, .en, .in_valid(vld[i]), .in_side(sd[i]),
      .in_rem(rem[i]), .in_quo(quo[i]), .in_div(dvs[i]),
      .out_valid(vld[i+1]), .out_side(sd[i+1]),
      .out_rem(rem[i+1]), .out_quo(quo[i+1]), .out_div(dvs[i+1])
    );
  end

  swalu_back u_back (
    .clk, .rst, .en, .in_valid(vld[DataW]), .side(sd[DataW]), .quo(quo[DataW]),
    .out_valid(m_tvalid), .value, .error_code
  );

  assign m_tdata = {6'd0, error_code, value};

  `SWA_ASSERT(a_ready_follows, (s_tready == (!m_tvalid || m_tready)),
    "ready mismatch")
  `SWA_ASSERT(a_err_zero, (m_tvalid && error_code != ERR_NONE) |-> (value == '0),
    "overflow value not zero")
  `SWA_ASSERT(a_err_code, m_tvalid |-> (error_code != 2'd3), "bad error code")
  `SWA_ASSERT(a_hold, (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata),
    "stalled output changed")
endmodule

// ===== hdl/swalu_front.sv =====
`timescale 1ns / 1ps
// first stage: decode, add/sub, logic, shifts, compares, the multiply and the divider operand magnitudes
module swalu_front (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic [swalu_pkg::CmdW-1:0] cmd,
  input  logic signed [swalu_pkg::DataW-1:0] a,
  input  logic signed [swalu_pkg::DataW-1:0] b,
  output logic out_valid,
  output swalu_pkg::side_t side,
  output logic [swalu_pkg::DataW-1:0] mag_a,
  output logic [swalu_pkg::DataW-1:0] mag_b
);
  import swalu_pkg::*;

  logic [5:0] cnt;
  logic [DataW-1:0] shv;
  logic sgn;
  logic [DataW-1:0] simple_v;
  logic signed [63:0] ex_v;
  side_t side_next;

  assign cnt = b[5:0] & CountMask;
  assign sgn = a[DataW-1];

  always_comb begin
    shv = '0;
    if (cnt == 6'd0) begin
      shv = a;
    end else if (cnt >= 6'd32) begin
      if (cmd == CMD_SLA) shv = {sgn, {(DataW-1){1'b0}}};
      else if (cmd == CMD_SRA) shv = {DataW{sgn}};
    end else begin
      case (cmd)
        CMD_SLA: shv = (a << cnt[4:0]) | {sgn, {(DataW-1){1'b0}}};
        CMD_SLL: shv = a << cnt[4:0];
        CMD_SRA: shv = a >>> cnt[4:0];
        default: shv = a >> cnt[4:0];
      endcase
    end
  end

  always_comb begin
    simple_v = '0;
    ex_v = '0;
    case (cmd) inside
      CMD_ADD: ex_v = 64'(a) + 64'(b);
      CMD_SUB: ex_v = 64'(a) - 64'(b);
      CMD_MUL: ex_v = 64'(a) * 64'(b);
      CMD_AND: simple_v = a & b;
      CMD_OR:  simple_v = a | b;
      CMD_XOR: simple_v = a ^ b;
      CMD_SLA, CMD_SLL, CMD_SRA, CMD_SRL: simple_v = shv;
      CMD_EQ: simple_v = DataW'(a == b);
      CMD_NE: simple_v = DataW'(a != b);
      CMD_LE: simple_v = DataW'(a <= b);
      CMD_LT: simple_v = DataW'(a < b);
      CMD_GE: simple_v = DataW'(a >= b);
      CMD_GT: simple_v = DataW'(a > b);
      default: simple_v = '0;
    endcase
    side_next.cmd = cmd;
    side_next.simple = simple_v;
    side_next.simple_err = ERR_NONE;
    side_next.exact = ex_v;
    side_next.quot_neg = a[DataW-1] ^ b[DataW-1];
    side_next.div_zero = (b == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      side <= side_next;
      mag_a <= sgn ? DataW'(-a) : a;
      mag_b <= b[DataW-1] ? DataW'(-b) : b;
    end
  end
endmodule

// ===== hdl/swalu_div_stage.sv =====
`timescale 1ns / 1ps
// one restoring step of the unsigned divider, one quotient bit per stage
module swalu_div_stage (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  swalu_pkg::side_t in_side,
  input  logic [swalu_pkg::DataW-1:0] in_rem,
  input  logic [swalu_pkg::DataW-1:0] in_quo,
  input  logic [swalu_pkg::DataW-1:0] in_div,
  output logic out_valid,
  output swalu_pkg::side_t out_side,
  output logic [swalu_pkg::DataW-1:0] out_rem,
  output logic [swalu_pkg::DataW-1:0] out_quo,
  output logic [swalu_pkg::DataW-1:0] out_div
);
  import swalu_pkg::*;

  logic [DataW:0] trial;
  logic [DataW:0] shifted;

  // quo holds remaining dividend bits at the top, quotient bits fill below
  assign shifted = {in_rem, in_quo[DataW-1]};
  assign trial = shifted - {1'b0, in_div};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      out_side <= in_side;
      out_div <= in_div;
      if (!trial[DataW]) begin
        out_rem <= trial[DataW-1:0];
        out_quo <= {in_quo[DataW-2:0], 1'b1};
      end else begin
        out_rem <= shifted[DataW-1:0];
        out_quo <= {in_quo[DataW-2:0], 1'b0};
      end
    end
  end
endmodule

// ===== hdl/swalu_back.sv =====
`timescale 1ns / 1ps
// last stage: sign fix of the quotient, range check and result select
module swalu_back (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  swalu_pkg::side_t side,
  input  logic [swalu_pkg::DataW-1:0] quo,
  output logic out_valid,
  output logic [swalu_pkg::DataW-1:0] value,
  output logic [swalu_pkg::ErrW-1:0] error_code
);
  import swalu_pkg::*;

  logic signed [63:0] ex;
  logic [DataW-1:0] v_next;
  logic [ErrW-1:0] e_next;

  always_comb begin
    ex = side.exact;
    if (side.cmd == CMD_DIV)
      ex = side.quot_neg ? -$signed({32'd0, quo}) : $signed({32'd0, quo});
    v_next = side.simple;
    e_next = side.simple_err;
    if (side.cmd == CMD_ADD || side.cmd == CMD_SUB || side.cmd == CMD_MUL ||
        (side.cmd == CMD_DIV && !side.div_zero)) begin
      if (ex > 64'sd2147483647) begin
        v_next = '0;
        e_next = ERR_HIGH;
      end else if (ex < -64'sd2147483648) begin
        v_next = '0;
        e_next = ERR_LOW;
      end else begin
        v_next = ex[DataW-1:0];
        e_next = ERR_NONE;
      end
    end else if (side.cmd == CMD_DIV) begin
      v_next = '0;
      e_next = ERR_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      value <= v_next;
      error_code <= e_next;
    end
  end
endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import swalu_pkg::*;

  // pipe is 34 stages deep, give the tail some margin
  localparam int unsigned PipeDepth = 34;
  localparam int unsigned StallLimit = 4000;

  typedef struct {
    logic [31:0] value;
    logic [1:0]  err;
  } alu_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  // command [4:0], operand_a [36:5], operand_b [68:37], zero fill to 72
  logic [71:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  // value [31:0], error_code [33:32], zero fill to 40
  logic [39:0] m_tdata;

  alu_result_t result_queue[$];
  int unsigned mismatch_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned sink_wait = 0;
  bit hold_off = 1'b0;
  bit sink_random = 1'b1;

  always #4 clk = ~clk;

  signed_word_alu_with_overflow u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  // predicted result of one word
  function automatic alu_result_t alu_predict(cmd_t cmd, logic [31:0] a, logic [31:0] b);
    alu_result_t r;
    longint sa, sb, exact;
    bit arith;
    int unsigned cnt;
    sa = longint'($signed(a));
    sb = longint'($signed(b));
    exact = 0;
    arith = 1'b0;
    cnt = 32'(b[5:0]);
    r.value = '0;
    r.err = ERR_NONE;
    case (cmd) inside
      CMD_ADD: begin exact = sa + sb; arith = 1'b1; end
      CMD_SUB: begin exact = sa - sb; arith = 1'b1; end
      CMD_MUL: begin exact = sa * sb; arith = 1'b1; end
      CMD_DIV: begin
        // divide by zero is quietly 0
        if (sb != 0) begin
          exact = sa / sb;
          arith = 1'b1;
        end
      end
      CMD_AND: r.value = a & b;
      CMD_OR: r.value = a | b;
      CMD_XOR: r.value = a ^ b;
      CMD_SLA, CMD_SLL, CMD_SRA, CMD_SRL: begin
        if (cnt == 0) r.value = a;
        else if (cnt >= 32) begin
          if (cmd == CMD_SLA) r.value = {a[31], 31'b0};
          else if (cmd == CMD_SRA) r.value = {32{a[31]}};
          else r.value = '0;
        end else if (cmd == CMD_SLA) r.value = (a << cnt) | {a[31], 31'b0};
        else if (cmd == CMD_SLL) r.value = a << cnt;
        else if (cmd == CMD_SRA) r.value = $unsigned($signed(a) >>> cnt);
        else r.value = a >> cnt;
      end
      CMD_EQ: r.value = 32'(sa == sb);
      CMD_NE: r.value = 32'(sa != sb);
      CMD_LE: r.value = 32'(sa <= sb);
      CMD_LT: r.value = 32'(sa < sb);
      CMD_GE: r.value = 32'(sa >= sb);
      CMD_GT: r.value = 32'(sa > sb);
      default: ;
    endcase
    if (arith) begin
      if (exact > 64'sd2147483647) r.err = ERR_HIGH;
      else if (exact < -64'sd2147483648) r.err = ERR_LOW;
      else r.value = exact[31:0];
    end
    return r;
  endfunction

  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // send one word, predict it at the accepting edge; cmd is raw 5 bits
  task automatic send_word(logic [4:0] cmd, logic [31:0] a, logic [31:0] b, bit gaps = 1);
    int unsigned g;
    g = gaps ? gap_len() : 0;
    if (g != 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {3'b0, b, a, cmd};
    do @(posedge clk); while (!s_tready);
    result_queue.push_back(alu_predict(cmd_t'(cmd), a, b));
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (result_queue.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(5))
      0: return 32'h8000_0000 + $urandom_range(3);
      1: return 32'h7fff_ffff - $urandom_range(3);
      2: return $urandom_range(8) - 4;
      3: return $urandom_range(65535) - 32768;
      default: return $urandom();
    endcase
  endfunction

  // extremes and every listed corner, once each
  task automatic test_directed();
    send_word(CMD_ADD, 32'h7fff_ffff, 32'h1);
    send_word(CMD_ADD, 32'h8000_0000, 32'hffff_ffff);
    send_word(CMD_SUB, 32'h8000_0000, 32'h1);
    send_word(CMD_SUB, 32'h7fff_ffff, 32'hffff_ffff);
    send_word(CMD_MUL, 32'h8000_0000, 32'hffff_ffff);
    send_word(CMD_MUL, 32'h8000_0000, 32'h2);
    send_word(CMD_DIV, 32'h8000_0000, 32'hffff_ffff);
    send_word(CMD_DIV, 32'h1234_5678, 32'h0);
    send_word(CMD_DIV, 32'hffff_fff9, 32'h2);
    send_word(CMD_AND, 32'hffff_ffff, 32'h5555_aaaa);
    send_word(CMD_OR, 32'h0, 32'haaaa_5555);
    send_word(CMD_XOR, 32'hffff_ffff, 32'h0f0f_0f0f);
    send_word(CMD_SLA, 32'h8000_0001, 32'h0);
    send_word(CMD_SLA, 32'hc000_0001, 32'h3f);
    send_word(CMD_SLL, 32'hffff_ffff, 32'h20);
    send_word(CMD_SRA, 32'h8000_0000, 32'h21);
    send_word(CMD_SRA, 32'h8000_0000, 32'h1f);
    send_word(CMD_SRL, 32'hffff_ffff, 32'hffff_ffc1);
    send_word(CMD_EQ, 32'h8000_0000, 32'h8000_0000);
    send_word(CMD_NE, 32'h8000_0000, 32'h7fff_ffff);
    send_word(CMD_LE, 32'h8000_0000, 32'h7fff_ffff);
    send_word(CMD_LT, 32'h7fff_ffff, 32'h8000_0000);
    send_word(CMD_GE, 32'h5, 32'h5);
    send_word(CMD_GT, 32'h0, 32'hffff_ffff);
    send_word(5'd31, 32'hffff_ffff, 32'hffff_ffff);
  endtask

  task automatic test_random(int unsigned n);
    logic [4:0] cmd;
    repeat (n) begin
      // mostly defined commands, some unused codes
      cmd = ($urandom_range(9) == 0) ? 5'($urandom_range(31, 17)) : 5'($urandom_range(16));
      send_word(cmd, rand_operand(), rand_operand());
    end
  endtask

  // sink holds off long enough for the pipe to fill, sender keeps offering
  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      test_random(80);
      begin
        repeat (150) @(posedge clk);
        hold_off = 1'b0;
      end
    join
    drain();
  endtask

  // back to back words with the sink always ready
  task automatic test_full_rate();
    sink_random = 1'b0;
    repeat (200) send_word(5'($urandom_range(16)), $urandom(), $urandom(), 0);
    drain();
    sink_random = 1'b1;
  endtask

  // sink side: random stalls, mostly short with a rare long one,
  // unless held off or running flat out
  always @(posedge clk) begin
    if (rst || hold_off) begin
      m_tready <= 1'b0;
    end else if (!sink_random) begin
      m_tready <= 1'b1;
    end else if (sink_wait != 0) begin
      sink_wait <= sink_wait - 1;
      m_tready <= 1'b0;
    end else if ($urandom_range(99) < 3) begin
      sink_wait <= $urandom_range(30, 8);
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) < 70) || ($urandom_range(99) < 10 && m_tready);
    end
  end

  // result checker
  always @(posedge clk) begin
    alu_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (result_queue.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected word %h", m_tdata);
      end else begin
        want = result_queue.pop_front();
        if (m_tdata[31:0] !== want.value || m_tdata[33:32] !== want.err) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected value %h err %0d, got value %h err %0d",
                     want.value, want.err, m_tdata[31:0], m_tdata[33:32]);
        end
      end
    end
  end

  // watchdog: cycles with no handshake on either side
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    drain();
    test_backpressure();
    test_full_rate();
    test_random(1600);
    drain();
    repeat (PipeDepth + 10) @(posedge clk);
    if (mismatch_count == 0 && result_queue.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
